// ----- src/vxhp_pkg.sv -----
// shared types and constants of the vxlan header parser
`timescale 1ns / 1ps

package vxhp_pkg;

  // ethertype and protocol codes
  localparam logic [7:0]  ETH_TYPE_HI     = 8'h08;
  localparam logic [7:0]  ETH_TYPE_LO     = 8'h00;
  localparam logic [7:0]  PROTO_TCP       = 8'd6;
  localparam logic [7:0]  PROTO_UDP       = 8'd17;
  localparam logic [3:0]  IP_VERSION4     = 4'd4;
  localparam logic [3:0]  IHL_MIN         = 4'd5;

  localparam logic [15:0] TUNNEL_PORT_RST = 16'd8472;

  // fixed positions in the outer frame
  localparam logic [7:0]  OFS_ETYPE_HI    = 8'd12;
  localparam logic [7:0]  OFS_ETYPE_LO    = 8'd13;
  localparam logic [7:0]  OFS_OUTER_IP    = 8'd14;
  localparam logic [7:0]  OFS_OUTER_PROTO = 8'd23;
  localparam logic [7:0]  OFS_OUTER_ADDR  = 8'd26;
  localparam logic [7:0]  OFS_OUTER_LAST  = 8'd33;
  localparam logic [7:0]  OFS_MAX         = 8'hFF;

  // header lengths
  localparam logic [7:0]  UDP_HDR_LEN     = 8'd8;
  localparam logic [7:0]  VXLAN_HDR_LEN   = 8'd8;
  localparam logic [7:0]  ETH_HDR_LEN     = 8'd14;
  localparam logic [7:0]  IPV4_MIN_LEN    = 8'd20;
  localparam logic [7:0]  TCP_MIN_LEN     = 8'd20;

  // one frame byte with its marks
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       dir;
  } beat_t;

  // one parse result
  typedef struct packed {
    logic        valid;
    logic [31:0] outer_src;
    logic [31:0] outer_dst;
    logic [31:0] inner_src;
    logic [31:0] inner_dst;
    logic [23:0] vni;
    logic [15:0] inner_sport;
    logic [15:0] inner_dport;
    logic [7:0]  inner_proto;
    logic [15:0] inner_len;
    logic [7:0]  flags;
    logic        dir;
  } res_t;

endpackage

// ----- src/vxhp_parser.sv -----
// per-frame parse state and result logic of the vxlan header parser
`timescale 1ns / 1ps

module vxhp_parser (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  vxhp_pkg::beat_t beat_i,
  input  logic [15:0]     tunnel_port_i,
  output vxhp_pkg::res_t  res_o
);
  import vxhp_pkg::*;

  logic [7:0]  ofs_q;
  logic [3:0]  oihl_q, oihl_d;
  logic [3:0]  iihl_q, iihl_d;
  logic        ok_q, ok_d;
  logic [31:0] oports_q, oports_d;
  logic [63:0] oaddr_q, oaddr_d;
  logic [63:0] iaddr_q, iaddr_d;
  logic [23:0] vni_q, vni_d;
  logic [7:0]  flags_q, flags_d;
  logic [7:0]  proto_q, proto_d;
  logic [15:0] ilen_q, ilen_d;
  logic [31:0] iports_q, iports_d;

  logic [7:0]  p, b;
  logic [7:0]  u, v, e, ip, t;
  logic [7:0]  need;
  logic [8:0]  len;
  logic        fail, frame_ok, ports_ok;

  always_comb begin
    p = ofs_q;
    b = beat_i.data;

    // header positions, with this byte's ihl taken into account
    oihl_d = (p == OFS_OUTER_IP) ? b[3:0] : oihl_q;
    u  = OFS_OUTER_IP + {2'b00, oihl_d, 2'b00};
    v  = u + UDP_HDR_LEN;
    e  = v + VXLAN_HDR_LEN;
    ip = e + ETH_HDR_LEN;
    iihl_d = (p == ip) ? b[3:0] : iihl_q;
    t  = ip + {2'b00, iihl_d, 2'b00};

    oports_d = (p >= u && p <= u + 8'd3) ? {oports_q[23:0], b} : oports_q;
    oaddr_d  = (p >= OFS_OUTER_ADDR && p <= OFS_OUTER_LAST) ? {oaddr_q[55:0], b} : oaddr_q;
    flags_d  = (p == v) ? b : flags_q;
    vni_d    = (p >= v + 8'd4 && p <= v + 8'd6) ? {vni_q[15:0], b} : vni_q;
    ilen_d   = (p == ip + 8'd2 || p == ip + 8'd3) ? {ilen_q[7:0], b} : ilen_q;
    proto_d  = (p == ip + 8'd9) ? b : proto_q;
    iaddr_d  = (p >= ip + 8'd12 && p <= ip + 8'd19) ? {iaddr_q[55:0], b} : iaddr_q;
    iports_d = (p >= t && p <= t + 8'd3) ? {iports_q[23:0], b} : iports_q;

    fail = 1'b0;
    if (p == OFS_ETYPE_HI && b != ETH_TYPE_HI) fail = 1'b1;
    if (p == OFS_ETYPE_LO && b != ETH_TYPE_LO) fail = 1'b1;
    if (p == OFS_OUTER_IP && b[3:0] < IHL_MIN) fail = 1'b1;
    if (p == OFS_OUTER_PROTO && b != PROTO_UDP) fail = 1'b1;
    // neither udp port matches the tunnel port
    if (p == u + 8'd3 && oports_d[31:16] != tunnel_port_i
        && oports_d[15:0] != tunnel_port_i) fail = 1'b1;
    if (p == e + 8'd12 && b != ETH_TYPE_HI) fail = 1'b1;
    if (p == e + 8'd13 && b != ETH_TYPE_LO) fail = 1'b1;
    if (p == ip && (b[7:4] != IP_VERSION4 || b[3:0] < IHL_MIN)) fail = 1'b1;
    ok_d = ok_q & ~fail;

    len      = {1'b0, p} + 9'd1;
    frame_ok = ok_d && (len >= {1'b0, ip} + {1'b0, IPV4_MIN_LEN});
    need     = (proto_d == PROTO_TCP) ? TCP_MIN_LEN :
               ((proto_d == PROTO_UDP) ? UDP_HDR_LEN : 8'd0);
    ports_ok = (need != 8'd0) && (len >= {1'b0, t} + {1'b0, need});

    res_o             = '0;
    res_o.dir         = beat_i.dir;
    if (frame_ok) begin
      res_o.valid       = 1'b1;
      res_o.outer_src   = oaddr_d[63:32];
      res_o.outer_dst   = oaddr_d[31:0];
      res_o.inner_src   = iaddr_d[63:32];
      res_o.inner_dst   = iaddr_d[31:0];
      res_o.vni         = vni_d;
      res_o.inner_proto = proto_d;
      res_o.inner_len   = ilen_d;
      res_o.flags       = flags_d;
      if (ports_ok) begin
        res_o.inner_sport = iports_d[31:16];
        res_o.inner_dport = iports_d[15:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ofs_q    <= '0;
      oihl_q   <= '0;
      iihl_q   <= '0;
      ok_q     <= 1'b1;
      oports_q <= '0;
      oaddr_q  <= '0;
      iaddr_q  <= '0;
      vni_q    <= '0;
      flags_q  <= '0;
      proto_q  <= '0;
      ilen_q   <= '0;
      iports_q <= '0;
    end else if (step_i) begin
      if (beat_i.last) begin
        // frame done, start over
        ofs_q    <= '0;
        oihl_q   <= '0;
        iihl_q   <= '0;
        ok_q     <= 1'b1;
        oports_q <= '0;
        oaddr_q  <= '0;
        iaddr_q  <= '0;
        vni_q    <= '0;
        flags_q  <= '0;
        proto_q  <= '0;
        ilen_q   <= '0;
        iports_q <= '0;
      end else begin
        ofs_q    <= (p != OFS_MAX) ? p + 8'd1 : p;
        oihl_q   <= oihl_d;
        iihl_q   <= iihl_d;
        ok_q     <= ok_d;
        oports_q <= oports_d;
        oaddr_q  <= oaddr_d;
        iaddr_q  <= iaddr_d;
        vni_q    <= vni_d;
        flags_q  <= flags_d;
        proto_q  <= proto_d;
        ilen_q   <= ilen_d;
        iports_q <= iports_d;
      end
    end
  end

endmodule

// ----- src/vxlan_header_parser.sv -----
// top level of the vxlan header parser
//
// usage:
// - input channel: one frame byte per transaction (frame_byte_i) with a final
//   byte mark (frame_end_i) and a direction bit (direction_i)
// - output channel: one result transaction per frame, issued for the byte
//   that carries frame_end_i; valid_res_o low marks a failed or short frame,
//   and then every field but direction_out_o is zero
// - tunnel port register: written by cfg_we_i / cfg_wdata_i; the user must write it only
//   while idle, the block itself does not enforce it; 8472 after reset
// - throughput: one byte per cycle while no final byte is held; non-final bytes keep flowing
//   while a result waits on a stalled receiver
// - the result is offered from the result register, loaded when the final byte
//   leaves the input register (input register, then result register)
// - a final byte waits in the input register while the previous result is
//   still stalled, and the input channel stalls until that result is taken
// - reset clears the byte offset, all captured fields and both registers'
//   valid flags; the receiver can stall any result indefinitely, it is held
`timescale 1ns / 1ps

module vxlan_header_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  // byte input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  frame_byte_i,
  input  logic        frame_end_i,
  input  logic        direction_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        valid_res_o,
  output logic [31:0] outer_source_addr_o,
  output logic [31:0] outer_dest_addr_o,
  output logic [31:0] inner_source_addr_o,
  output logic [31:0] inner_dest_addr_o,
  output logic [23:0] network_id_o,
  output logic [15:0] inner_src_port_o,
  output logic [15:0] inner_dst_port_o,
  output logic [7:0]  inner_protocol_o,
  output logic [15:0] inner_length_o,
  output logic [7:0]  tunnel_flags_o,
  output logic        direction_out_o
);
  import vxhp_pkg::*;

  logic [15:0] tport_q;
  beat_t       a_q;
  logic        a_valid_q;
  res_t        res_q, res_d;
  logic        out_valid_q;

  logic        a_blocked, a_fire, in_acc, res_load;

  // a final byte must wait while the result register is held
  assign a_blocked  = a_q.last & out_valid_q & out_stall_i;
  assign in_stall_o = a_valid_q & a_blocked;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign a_fire     = a_valid_q & ~a_blocked;
  assign res_load   = a_fire & a_q.last;

  // tunnel port register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tport_q <= TUNNEL_PORT_RST;
    end else if (cfg_we_i) begin
      tport_q <= cfg_wdata_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_acc) begin
      a_valid_q <= 1'b1;
    end else if (a_fire) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_q <= '{data: frame_byte_i, last: frame_end_i, dir: direction_i};
    end
  end

  // field capture and checks
  vxhp_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (a_fire),
    .beat_i        (a_q),
    .tunnel_port_i (tport_q),
    .res_o         (res_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign valid_res_o         = res_q.valid;
  assign outer_source_addr_o = res_q.outer_src;
  assign outer_dest_addr_o   = res_q.outer_dst;
  assign inner_source_addr_o = res_q.inner_src;
  assign inner_dest_addr_o   = res_q.inner_dst;
  assign network_id_o        = res_q.vni;
  assign inner_src_port_o    = res_q.inner_sport;
  assign inner_dst_port_o    = res_q.inner_dport;
  assign inner_protocol_o    = res_q.inner_proto;
  assign inner_length_o      = res_q.inner_len;
  assign tunnel_flags_o      = res_q.flags;
  assign direction_out_o     = res_q.dir;

  // a new result only comes from a final byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(a_valid_q && a_q.last))
    else $error("result without a final byte");

  // a stalled result is neither dropped nor overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(res_q))
    else $error("stalled result lost");

  // a rejected frame carries zero fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !valid_res_o |-> outer_source_addr_o == 32'd0 &&
      network_id_o == 24'd0 && inner_src_port_o == 16'd0 && inner_length_o == 16'd0)
    else $error("rejected frame with nonzero fields");

  // inner ports only for tcp or udp
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (inner_src_port_o != 16'd0 || inner_dst_port_o != 16'd0) |->
      inner_protocol_o == PROTO_TCP || inner_protocol_o == PROTO_UDP)
    else $error("inner ports for a protocol without ports");

endmodule
